// ----- src/swbph_pkg.sv -----
// shared types and constants of the sliding window bin pattern histogram
package swbph_pkg;

  localparam int CFG_BITS       = 24;
  localparam int WIDTH_BITS     = 8;
  localparam int WSUM_BITS      = 10;
  localparam int TICK_BITS      = 11;
  localparam int PATTERN_BITS   = 6;
  localparam int OUT_COUNT_BITS = 32;
  localparam int GROUP_SIZE     = 32;
  localparam int APB_DATA_BITS  = 32;
  localparam int APB_ADDR_BITS  = 3;

  localparam logic [TICK_BITS-1:0] TICKS_MAX        = '1;
  localparam logic [CFG_BITS-1:0]  BIN_WIDTHS_RESET = 24'h010101;

  // register index, taken from paddr bit 2
  localparam logic REG_BIN_WIDTHS = 1'b0;

  // one tick moving down the pattern pipeline
  typedef struct packed {
    logic                    vld;
    logic                    cnt;
    logic                    last;
    logic [PATTERN_BITS-1:0] pat;
  } item_t;

endpackage

// ----- src/sliding_window_bin_pattern_histogram.sv -----
// Binned event pattern histogram over two event trains.
// Input channel (in_valid/in_ready): one beat per time tick, carrying the
// Y and X event flags and last_tick on the final tick of a recording.
// Ticks are taken one per cycle when in_ready, each shifting into a row of
// MAX_WINDOW history cells. Two registered OR stages reduce the cells into a
// 2*NUM_BINS pattern, and the pattern count is updated by a read-modify-write
// on a small ram, with the previous write forwarded, so the sustained rate is
// one tick per cycle. Bin widths come from the APB bin_widths register.
// Output channel (out_valid/out_ready): after the last tick all
// 2^(2*NUM_BINS) counts are read out in rising pattern order, last set on
// the final beat. The last tick passes stages s0, s1, s2 and write-back
// before the readout starts; then one beat per cycle while out_ready is high;
// an output register and a skid entry hold results while the receiver stalls.
// in_ready is low from the last tick until the final count has been read
// from the ram, then a new recording begins. Reset clears history, tick count
// and counts at once; each readout clears them too, counts as they are read,
// through per-pattern valid bits, with no clearing pass.
module sliding_window_bin_pattern_histogram #(
  parameter int NUM_BINS   = 3,
  parameter int MAX_WINDOW = 1024,
  parameter int COUNT_BITS = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_y_event,
  input  logic                                  in_x_event,
  input  logic                                  in_last_tick,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [swbph_pkg::PATTERN_BITS-1:0]    out_pattern,
  output logic [swbph_pkg::OUT_COUNT_BITS-1:0]  out_window_count,
  output logic                                  out_last,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [swbph_pkg::APB_ADDR_BITS-1:0]   paddr,
  input  logic [swbph_pkg::APB_DATA_BITS-1:0]   pwdata,
  output logic [swbph_pkg::APB_DATA_BITS-1:0]   prdata,
  output logic                                  pready
);

  localparam int GS         = swbph_pkg::GROUP_SIZE;
  localparam int NUM_GROUPS = (MAX_WINDOW + GS - 1) / GS;
  localparam int WB         = swbph_pkg::WIDTH_BITS;
  localparam int SB         = swbph_pkg::WSUM_BITS;

  // configuration
  logic [swbph_pkg::CFG_BITS-1:0] bin_widths_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_widths_r <= swbph_pkg::BIN_WIDTHS_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == swbph_pkg::REG_BIN_WIDTHS)) begin
      bin_widths_r <= pwdata[swbph_pkg::CFG_BITS-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == swbph_pkg::REG_BIN_WIDTHS) ?
                  swbph_pkg::APB_DATA_BITS'(bin_widths_r) : '0;

  // bin age ranges: bin 0 is the oldest part of the window, age 0 the newest tick
  logic [NUM_BINS-1:0][WB-1:0] wid;
  logic [NUM_BINS-1:0][SB-1:0] lo;
  logic [NUM_BINS-1:0][SB-1:0] hi;
  logic [SB-1:0]               win_w;

  always_comb begin
    logic [SB-1:0] acc;
    acc = '0;
    for (int j = NUM_BINS - 1; j >= 0; j--) begin
      wid[j] = bin_widths_r[j*WB +: WB];
      if (wid[j] == '0) begin
        wid[j] = WB'(1);
      end
      lo[j] = acc;
      hi[j] = acc + SB'(wid[j]) - 1'b1;
      acc   = acc + SB'(wid[j]);
    end
    win_w = acc;
  end

  // tick intake
  logic                             in_acc;
  logic                             busy_r;
  logic                             drain_done;
  logic [swbph_pkg::TICK_BITS-1:0]  ticks_seen_r, ticks_seen_nxt;
  logic [swbph_pkg::TICK_BITS-1:0]  ticks_inc;
  logic                             cnt_c;
  swbph_pkg::item_t                 s0_r, s1_r, s2_r;
  swbph_pkg::item_t                 s0_nxt, s2_nxt;
  logic                             hist_clear;

  assign in_ready = !busy_r;
  assign in_acc   = in_valid && in_ready;

  assign ticks_inc = (ticks_seen_r == swbph_pkg::TICKS_MAX) ? ticks_seen_r :
                     ticks_seen_r + 1'b1;
  assign cnt_c = (int'(win_w) <= MAX_WINDOW) &&
                 (ticks_inc >= swbph_pkg::TICK_BITS'(win_w));
  assign ticks_seen_nxt = !in_acc      ? ticks_seen_r :
                          in_last_tick ? '0 : ticks_inc;

  always_comb begin
    s0_nxt      = '0;
    s0_nxt.vld  = in_acc;
    s0_nxt.cnt  = cnt_c;
    s0_nxt.last = in_last_tick;
  end

  // history is cleared in the cycle after the last tick is accepted, once stage one has it
  assign hist_clear = s0_r.vld && s0_r.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_seen_r <= '0;
      busy_r       <= 1'b0;
      s0_r         <= '0;
      s1_r         <= '0;
      s2_r         <= '0;
    end else begin
      ticks_seen_r <= ticks_seen_nxt;
      s0_r         <= s0_nxt;
      s1_r         <= s0_r;
      s2_r         <= s2_nxt;
      if (in_acc && in_last_tick) begin
        busy_r <= 1'b1;
      end else if (drain_done) begin
        busy_r <= 1'b0;
      end
    end
  end

  // row of history cells
  logic                y_q   [MAX_WINDOW];
  logic                x_q   [MAX_WINDOW];
  logic [NUM_BINS-1:0] y_hit [MAX_WINDOW];
  logic [NUM_BINS-1:0] x_hit [MAX_WINDOW];

  for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
    logic y_src;
    logic x_src;
    if (k == 0) begin : g_head
      assign y_src = in_y_event;
      assign x_src = in_x_event;
    end else begin : g_link
      assign y_src = y_q[k-1];
      assign x_src = x_q[k-1];
    end
    swbph_cell #(
      .NUM_BINS (NUM_BINS),
      .AGE      (k)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (in_acc),
      .clear    (hist_clear),
      .y_in     (y_src),
      .x_in     (x_src),
      .lo       (lo),
      .hi       (hi),
      .y_out    (y_q[k]),
      .x_out    (x_q[k]),
      .y_hit    (y_hit[k]),
      .x_hit    (x_hit[k])
    );
  end

  // stage one: OR within groups of cells
  logic [NUM_BINS-1:0] grp_y_r [NUM_GROUPS];
  logic [NUM_BINS-1:0] grp_x_r [NUM_GROUPS];
  logic [NUM_BINS-1:0] grp_y_nxt [NUM_GROUPS];
  logic [NUM_BINS-1:0] grp_x_nxt [NUM_GROUPS];

  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      grp_y_nxt[g] = '0;
      grp_x_nxt[g] = '0;
      for (int i = 0; i < GS; i++) begin
        if (g * GS + i < MAX_WINDOW) begin
          grp_y_nxt[g] = grp_y_nxt[g] | y_hit[g*GS+i];
          grp_x_nxt[g] = grp_x_nxt[g] | x_hit[g*GS+i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      grp_y_r[g] <= grp_y_nxt[g];
      grp_x_r[g] <= grp_x_nxt[g];
    end
  end

  // stage two: OR across groups gives the pattern
  always_comb begin
    logic [NUM_BINS-1:0] y_any;
    logic [NUM_BINS-1:0] x_any;
    y_any = '0;
    x_any = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      y_any = y_any | grp_y_r[g];
      x_any = x_any | grp_x_r[g];
    end
    s2_nxt     = s1_r;
    s2_nxt.pat = swbph_pkg::PATTERN_BITS'({y_any, x_any});
  end

  swbph_hist #(
    .NUM_BINS   (NUM_BINS),
    .COUNT_BITS (COUNT_BITS)
  ) u_hist (
    .clk              (clk),
    .rst_n            (rst_n),
    .a_item           (s2_r),
    .drain_done       (drain_done),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_pattern      (out_pattern),
    .out_window_count (out_window_count),
    .out_last         (out_last)
  );

endmodule

// ----- src/swbph_cell.sv -----
// one history cell: holds a tick of both trains and flags the bin it falls into
module swbph_cell #(
  parameter int NUM_BINS = 3,
  parameter int AGE      = 0
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic                                            shift_en,
  input  logic                                            clear,
  input  logic                                            y_in,
  input  logic                                            x_in,
  input  logic [NUM_BINS-1:0][swbph_pkg::WSUM_BITS-1:0]  lo,
  input  logic [NUM_BINS-1:0][swbph_pkg::WSUM_BITS-1:0]  hi,
  output logic                                            y_out,
  output logic                                            x_out,
  output logic [NUM_BINS-1:0]                             y_hit,
  output logic [NUM_BINS-1:0]                             x_hit
);

  localparam logic [swbph_pkg::WSUM_BITS-1:0] AGE_V = swbph_pkg::WSUM_BITS'(AGE);

  logic y_r;
  logic x_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      y_r <= 1'b0;
      x_r <= 1'b0;
    end else if (clear) begin
      y_r <= 1'b0;
      x_r <= 1'b0;
    end else if (shift_en) begin
      y_r <= y_in;
      x_r <= x_in;
    end
  end

  assign y_out = y_r;
  assign x_out = x_r;

  always_comb begin
    for (int j = 0; j < NUM_BINS; j++) begin
      y_hit[j] = y_r && (AGE_V >= lo[j]) && (AGE_V <= hi[j]);
      x_hit[j] = x_r && (AGE_V >= lo[j]) && (AGE_V <= hi[j]);
    end
  end

endmodule

// ----- src/swbph_ram.sv -----
// generic single write port, single read port ram with registered read
module swbph_ram #(
  parameter  int WIDTH     = 32,
  parameter  int DEPTH     = 64,
  localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- src/swbph_hist.sv -----
// pattern count store: read-modify-write per window and the readout run
module swbph_hist #(
  parameter int NUM_BINS   = 3,
  parameter int COUNT_BITS = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  swbph_pkg::item_t                      a_item,
  output logic                                  drain_done,
  input  logic                                  out_ready,
  output logic                                  out_valid,
  output logic [swbph_pkg::PATTERN_BITS-1:0]    out_pattern,
  output logic [swbph_pkg::OUT_COUNT_BITS-1:0]  out_window_count,
  output logic                                  out_last
);

  localparam int PAT_W   = 2 * NUM_BINS;
  localparam int NUM_PAT = 1 << PAT_W;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [PAT_W-1:0]      LAST_PAT  = PAT_W'(NUM_PAT - 1);

  typedef struct packed {
    logic [swbph_pkg::PATTERN_BITS-1:0]   pattern;
    logic [swbph_pkg::OUT_COUNT_BITS-1:0] count;
    logic                                 last;
  } result_t;

  swbph_pkg::item_t b_r;

  logic                  we;
  logic [PAT_W-1:0]      waddr;
  logic [PAT_W-1:0]      raddr;
  logic [COUNT_BITS-1:0] rdata;
  logic [COUNT_BITS-1:0] old_cnt;
  logic [COUNT_BITS-1:0] new_cnt;

  logic                  fwd_vld_r;
  logic [PAT_W-1:0]      fwd_addr_r;
  logic [COUNT_BITS-1:0] fwd_data_r;

  logic [NUM_PAT-1:0]    vbit_r;
  logic                  draining_r;
  logic [PAT_W-1:0]      rd_idx_r;
  logic                  issue;

  logic                  pend_r;
  logic [PAT_W-1:0]      pend_idx_r;
  logic                  pend_vb_r;
  logic [COUNT_BITS-1:0] pend_cnt;
  logic [swbph_pkg::OUT_COUNT_BITS-1:0] pend_sat;
  result_t               pend_res;

  logic                  out_vld_r, out_vld_nxt;
  logic                  skid_vld_r, skid_vld_nxt;
  result_t               out_res_r, out_res_nxt;
  result_t               skid_res_r, skid_res_nxt;
  logic [1:0]            occ;
  logic                  take;

  // window update side
  assign waddr = b_r.pat[PAT_W-1:0];
  assign we    = b_r.vld && b_r.cnt;
  assign raddr = draining_r ? rd_idx_r : a_item.pat[PAT_W-1:0];

  swbph_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (NUM_PAT)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (new_cnt),
    .raddr (raddr),
    .rdata (rdata)
  );

  // the write of the previous cycle is not yet visible in the read data
  always_comb begin
    if (fwd_vld_r && (fwd_addr_r == waddr)) begin
      old_cnt = fwd_data_r;
    end else if (vbit_r[waddr]) begin
      old_cnt = rdata;
    end else begin
      old_cnt = '0;
    end
    new_cnt = (old_cnt == COUNT_MAX) ? old_cnt : old_cnt + 1'b1;
  end

  // readout side
  assign occ  = {1'b0, out_vld_r} + {1'b0, skid_vld_r} + {1'b0, pend_r};
  assign take = out_vld_r && out_ready;
  assign issue = draining_r && ((occ - {1'b0, take}) <= 2'd1);
  assign drain_done = issue && (rd_idx_r == LAST_PAT);

  assign pend_cnt = pend_vb_r ? rdata : '0;

  generate
    if (COUNT_BITS > swbph_pkg::OUT_COUNT_BITS) begin : g_sat
      assign pend_sat = (|pend_cnt[COUNT_BITS-1:swbph_pkg::OUT_COUNT_BITS]) ? '1 :
                        pend_cnt[swbph_pkg::OUT_COUNT_BITS-1:0];
    end else begin : g_ext
      assign pend_sat = swbph_pkg::OUT_COUNT_BITS'(pend_cnt);
    end
  endgenerate

  always_comb begin
    pend_res.pattern = swbph_pkg::PATTERN_BITS'(pend_idx_r);
    pend_res.count   = pend_sat;
    pend_res.last    = (pend_idx_r == LAST_PAT);
  end

  // output register plus one skid entry
  always_comb begin
    out_vld_nxt  = out_vld_r;
    out_res_nxt  = out_res_r;
    skid_vld_nxt = skid_vld_r;
    skid_res_nxt = skid_res_r;
    if (!out_vld_r || take) begin
      if (skid_vld_r) begin
        out_vld_nxt  = 1'b1;
        out_res_nxt  = skid_res_r;
        skid_vld_nxt = pend_r;
        skid_res_nxt = pend_res;
      end else if (pend_r) begin
        out_vld_nxt = 1'b1;
        out_res_nxt = pend_res;
      end else begin
        out_vld_nxt = 1'b0;
      end
    end else if (pend_r) begin
      skid_vld_nxt = 1'b1;
      skid_res_nxt = pend_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_r        <= '0;
      fwd_vld_r  <= 1'b0;
      vbit_r     <= '0;
      draining_r <= 1'b0;
      rd_idx_r   <= '0;
      pend_r     <= 1'b0;
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      b_r        <= a_item;
      fwd_vld_r  <= we;
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
      pend_r     <= issue;
      if (we) begin
        vbit_r[waddr] <= 1'b1;
      end
      if (issue) begin
        vbit_r[rd_idx_r] <= 1'b0;
        rd_idx_r         <= rd_idx_r + 1'b1;
      end
      // last tick written back: start the readout run
      if (b_r.vld && b_r.last) begin
        draining_r <= 1'b1;
      end else if (drain_done) begin
        draining_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    fwd_addr_r <= waddr;
    fwd_data_r <= new_cnt;
    pend_idx_r <= rd_idx_r;
    pend_vb_r  <= vbit_r[rd_idx_r];
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  assign out_valid        = out_vld_r;
  assign out_pattern      = out_res_r.pattern;
  assign out_window_count = out_res_r.count;
  assign out_last         = out_res_r.last;

endmodule

// ----- sim/tb_sliding_window_bin_pattern_histogram.sv -----
// testbench for the sliding window bin pattern histogram: directed table, random recordings
`timescale 1ns / 100ps

module tb_sliding_window_bin_pattern_histogram;

  localparam int NUM_BINS      = 3;
  localparam int MAX_WINDOW    = 1024;
  localparam int COUNT_BITS    = 32;
  localparam int NUM_PATTERNS  = 1 << (2 * NUM_BINS);
  localparam int RING_BITS     = $clog2(MAX_WINDOW);
  localparam int RANDOM_TICKS  = 430;
  localparam int LONG_TICKS    = 300;
  localparam int SETTLE_CYCLES = 12;

  // bins of 80, 90 and 80 ticks
  localparam logic [swbph_pkg::CFG_BITS-1:0] LONG_WIDTHS = 24'h50_5A_50;

  // register index that holds nothing
  localparam logic REG_SPARE = 1'b1;

  typedef enum logic [1:0] {ROW_TICK, ROW_WIDTHS, ROW_SPARE} row_kind_t;

  typedef struct packed {
    logic                                 fixed;  // readout typed in: cnt at pat, zero elsewhere
    logic [swbph_pkg::PATTERN_BITS-1:0]   pat;
    logic [swbph_pkg::OUT_COUNT_BITS-1:0] cnt;
  } tick_note_t;

  typedef struct packed {
    logic [swbph_pkg::PATTERN_BITS-1:0]   pattern;
    logic [swbph_pkg::OUT_COUNT_BITS-1:0] window_count;
    logic                                 last;
  } count_beat_t;

  typedef struct packed {
    row_kind_t                           kind;
    logic                                y;
    logic                                x;
    logic                                last_tick;
    logic [swbph_pkg::APB_DATA_BITS-1:0] widths;
    tick_note_t                          note;
  } script_row_t;

  localparam tick_note_t PREDICT  = '0;
  localparam tick_note_t ALL_ZERO = '{1'b1, 6'd0, 32'd0};
  localparam tick_note_t ONLY_0   = '{1'b1, 6'd0, 32'd1};
  localparam tick_note_t ONLY_46  = '{1'b1, 6'd46, 32'd1};
  localparam tick_note_t ONLY_63  = '{1'b1, 6'd63, 32'd1};

  script_row_t script [28] = '{
    // lone last tick after reset: nothing counted
    '{ROW_TICK,   1'b0, 1'b0, 1'b1, 32'h0, ALL_ZERO},
    '{ROW_TICK,   1'b1, 1'b0, 1'b0, 32'h0, PREDICT},
    '{ROW_TICK,   1'b0, 1'b1, 1'b0, 32'h0, PREDICT},
    '{ROW_TICK,   1'b1, 1'b1, 1'b1, 32'h0, ONLY_46},
    '{ROW_TICK,   1'b1, 1'b1, 1'b0, 32'h0, PREDICT},
    '{ROW_TICK,   1'b1, 1'b1, 1'b0, 32'h0, PREDICT},
    '{ROW_TICK,   1'b1, 1'b1, 1'b1, 32'h0, ONLY_63},
    '{ROW_TICK,   1'b0, 1'b0, 1'b0, 32'h0, PREDICT},
    '{ROW_TICK,   1'b0, 1'b0, 1'b0, 32'h0, PREDICT},
    '{ROW_TICK,   1'b0, 1'b0, 1'b1, 32'h0, ONLY_0},
    // zero bytes mean width one, top byte ignored
    '{ROW_WIDTHS, 1'b0, 1'b0, 1'b0, 32'hFF00_0000, PREDICT},
    '{ROW_SPARE,  1'b0, 1'b0, 1'b0, 32'h00FF_FFFF, PREDICT},
    '{ROW_TICK,   1'b0, 1'b1, 1'b0, 32'h0, PREDICT},
    '{ROW_TICK,   1'b1, 1'b0, 1'b0, 32'h0, PREDICT},
    '{ROW_TICK,   1'b0, 1'b0, 1'b0, 32'h0, PREDICT},
    '{ROW_TICK,   1'b1, 1'b1, 1'b1, 32'h0, PREDICT},
    // widest window, recording far too short for it
    '{ROW_WIDTHS, 1'b0, 1'b0, 1'b0, 32'h00FF_FFFF, PREDICT},
    '{ROW_TICK,   1'b1, 1'b1, 1'b0, 32'h0, PREDICT},
    '{ROW_TICK,   1'b0, 1'b1, 1'b0, 32'h0, PREDICT},
    '{ROW_TICK,   1'b1, 1'b1, 1'b1, 32'h0, ALL_ZERO},
    '{ROW_WIDTHS, 1'b0, 1'b0, 1'b0, 32'h5A03_0201, PREDICT},
    '{ROW_TICK,   1'b1, 1'b0, 1'b0, 32'h0, PREDICT},
    '{ROW_TICK,   1'b0, 1'b1, 1'b0, 32'h0, PREDICT},
    '{ROW_TICK,   1'b0, 1'b0, 1'b0, 32'h0, PREDICT},
    '{ROW_TICK,   1'b1, 1'b0, 1'b0, 32'h0, PREDICT},
    '{ROW_TICK,   1'b0, 1'b1, 1'b0, 32'h0, PREDICT},
    '{ROW_TICK,   1'b1, 1'b1, 1'b0, 32'h0, PREDICT},
    '{ROW_TICK,   1'b0, 1'b0, 1'b1, 32'h0, PREDICT}
  };

  int density_pm [7] = '{0, 20, 100, 300, 500, 900, 1000};

  logic                                 clk = 1'b0;
  logic                                 rst_n = 1'b0;
  logic                                 in_valid = 1'b0;
  logic                                 in_ready;
  logic                                 in_y_event = 1'b0;
  logic                                 in_x_event = 1'b0;
  logic                                 in_last_tick = 1'b0;
  logic                                 out_valid;
  logic                                 out_ready = 1'b1;
  logic [swbph_pkg::PATTERN_BITS-1:0]   out_pattern;
  logic [swbph_pkg::OUT_COUNT_BITS-1:0] out_window_count;
  logic                                 out_last;
  logic                                 psel = 1'b0;
  logic                                 penable = 1'b0;
  logic                                 pwrite = 1'b0;
  logic [swbph_pkg::APB_ADDR_BITS-1:0]  paddr = '0;
  logic [swbph_pkg::APB_DATA_BITS-1:0]  pwdata = '0;
  logic [swbph_pkg::APB_DATA_BITS-1:0]  prdata;
  logic                                 pready;

  sliding_window_bin_pattern_histogram #(
    .NUM_BINS  (NUM_BINS),
    .MAX_WINDOW(MAX_WINDOW),
    .COUNT_BITS(COUNT_BITS)
  ) dut (.*);

  always #1 clk = ~clk;

  initial begin
    #10_000_000;
    $display("sliding_window_bin_pattern_histogram verification failed");
    $finish;
  end

  // model of the block
  logic [swbph_pkg::CFG_BITS-1:0]  widths_reg;
  logic [MAX_WINDOW-1:0]           y_ring;
  logic [MAX_WINDOW-1:0]           x_ring;
  logic [RING_BITS-1:0]            ring_pos;
  logic [swbph_pkg::TICK_BITS-1:0] tick_count;
  logic [COUNT_BITS-1:0]           pattern_counts [NUM_PATTERNS];

  count_beat_t pending_counts [$];
  tick_note_t  tick_notes [$];
  int          mismatches = 0;
  bit          tx_gappy = 1'b1;
  bit          rx_gappy = 1'b1;
  int          stall_left = 0;

  function automatic int unsigned width_of_bin(int j);
    logic [swbph_pkg::WIDTH_BITS-1:0] b;
    b = widths_reg[swbph_pkg::WIDTH_BITS*j +: swbph_pkg::WIDTH_BITS];
    return (b == 0) ? 1 : b;
  endfunction

  function automatic int unsigned window_span();
    int unsigned w;
    w = 0;
    for (int j = 0; j < NUM_BINS; j++) w += width_of_bin(j);
    return w;
  endfunction

  function automatic void clear_recording();
    y_ring = '0;
    x_ring = '0;
    ring_pos = '0;
    tick_count = '0;
    foreach (pattern_counts[p]) pattern_counts[p] = '0;
  endfunction

  function automatic void tally_tick(logic y, logic x, logic last_tick, tick_note_t note);
    int unsigned w;
    int unsigned off;
    int unsigned age;
    logic [RING_BITS-1:0]               pos;
    logic [swbph_pkg::PATTERN_BITS-1:0] pat;
    count_beat_t                        beat;
    w = window_span();
    ring_pos = ring_pos + 1'b1;
    y_ring[ring_pos] = y;
    x_ring[ring_pos] = x;
    if (tick_count != swbph_pkg::TICKS_MAX) tick_count = tick_count + 1'b1;
    if (w <= MAX_WINDOW && tick_count >= w) begin
      pat = '0;
      off = 0;
      // oldest tick of the window belongs to bin 0
      for (int j = 0; j < NUM_BINS; j++) begin
        for (int t = 0; t < width_of_bin(j); t++) begin
          age = w - 1 - off;
          pos = ring_pos - RING_BITS'(age);
          if (y_ring[pos]) pat[NUM_BINS + j] = 1'b1;
          if (x_ring[pos]) pat[j] = 1'b1;
          off++;
        end
      end
      if (pattern_counts[pat] != '1) pattern_counts[pat] = pattern_counts[pat] + 1'b1;
    end
    if (last_tick) begin
      for (int p = 0; p < NUM_PATTERNS; p++) begin
        beat.pattern = swbph_pkg::PATTERN_BITS'(p);
        if (note.fixed) begin
          beat.window_count = (p == note.pat) ? note.cnt : '0;
        end else begin
          beat.window_count = pattern_counts[p];
        end
        beat.last = (p == NUM_PATTERNS - 1);
        pending_counts.push_back(beat);
      end
      clear_recording();
    end
  endfunction

  // result check first, then the model takes the tick of the same edge
  always @(posedge clk) begin : count_check
    count_beat_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_counts.size() == 0) begin
          $error("count beat with none expected: pattern %0d count %0d",
                 out_pattern, out_window_count);
          mismatches++;
        end else begin
          want = pending_counts.pop_front();
          if (out_pattern !== want.pattern) begin
            $error("pattern: expected %0d, got %0d", want.pattern, out_pattern);
            mismatches++;
          end
          if (out_window_count !== want.window_count) begin
            $error("window_count: expected %0d, got %0d", want.window_count, out_window_count);
            mismatches++;
          end
          if (out_last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_last);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        tally_tick(in_y_event, in_x_event, in_last_tick, tick_notes.pop_front());
      end
    end
  end

  // receiver stalls in bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (rx_gappy && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 12);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_tick(input logic y, input logic x, input logic last_tick,
                           input tick_note_t note);
    int gap;
    gap = (tx_gappy && $urandom_range(0, 4) == 0) ? $urandom_range(1, 13) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tick_notes.push_back(note);
    in_valid <= 1'b1;
    in_y_event <= y;
    in_x_event <= x;
    in_last_tick <= last_tick;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic play_recording(input int len, input int y_pm, input int x_pm);
    for (int i = 0; i < len; i++) begin
      send_tick($urandom_range(0, 999) < y_pm, $urandom_range(0, 999) < x_pm,
                i == len - 1, PREDICT);
    end
  endtask

  // wait for the readout to drain and the pipeline to empty
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_counts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic [swbph_pkg::APB_DATA_BITS-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == swbph_pkg::REG_BIN_WIDTHS) widths_reg = data[swbph_pkg::CFG_BITS-1:0];
    // read the width register back
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {swbph_pkg::REG_BIN_WIDTHS, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[swbph_pkg::CFG_BITS-1:0] !== widths_reg) begin
      $error("bin_widths: expected %h, got %h", widths_reg, prdata[swbph_pkg::CFG_BITS-1:0]);
      mismatches++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    int sent;
    int len;
    int w;
    bit long_done;
    logic [swbph_pkg::APB_DATA_BITS-1:0] widths;
    widths_reg = swbph_pkg::BIN_WIDTHS_RESET;
    clear_recording();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[r]) begin
      case (script[r].kind)
        ROW_TICK: send_tick(script[r].y, script[r].x, script[r].last_tick, script[r].note);
        ROW_WIDTHS: begin
          settle();
          cfg_write(swbph_pkg::REG_BIN_WIDTHS, script[r].widths);
        end
        default: begin
          settle();
          cfg_write(REG_SPARE, script[r].widths);
        end
      endcase
    end

    sent = 0;
    long_done = 1'b0;
    while (sent < RANDOM_TICKS) begin
      // one long sparse recording with wide bins
      if (!long_done && sent >= 40) begin
        settle();
        widths = $urandom;
        widths[swbph_pkg::CFG_BITS-1:0] = LONG_WIDTHS;
        cfg_write(swbph_pkg::REG_BIN_WIDTHS, widths);
        play_recording(LONG_TICKS, 2, 2);
        sent += LONG_TICKS;
        long_done = 1'b1;
      end
      if (sent >= RANDOM_TICKS - 80) begin
        tx_gappy = 1'b0;
        rx_gappy = 1'b0;
      end else begin
        tx_gappy = ($urandom_range(0, 3) != 0);
        rx_gappy = ($urandom_range(0, 3) != 0);
      end
      if ($urandom_range(0, 2) == 0) begin
        settle();
        widths = $urandom;  // top byte rides along and is ignored
        case ($urandom_range(0, 9))
          0: widths[swbph_pkg::CFG_BITS-1:0] = '0;
          1: widths[swbph_pkg::CFG_BITS-1:0] = '1;
          2: widths[swbph_pkg::CFG_BITS-1:0] = swbph_pkg::BIN_WIDTHS_RESET;
          3, 4: begin
            for (int j = 0; j < NUM_BINS; j++) widths[8*j +: 8] = 8'($urandom_range(0, 15));
          end
          5: ;
          default: begin
            for (int j = 0; j < NUM_BINS; j++) widths[8*j +: 8] = 8'($urandom_range(0, 4));
          end
        endcase
        cfg_write(swbph_pkg::REG_BIN_WIDTHS, widths);
      end
      w = window_span();
      len = $urandom_range(1, (w + 40 > 80) ? 80 : w + 40);
      play_recording(len, density_pm[$urandom_range(0, 6)], density_pm[$urandom_range(0, 6)]);
      sent += len;
    end

    settle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("sliding_window_bin_pattern_histogram verification clean");
    end else begin
      $display("sliding_window_bin_pattern_histogram verification failed");
    end
    $finish;
  end

endmodule
